// ===== design/tass_pkg.sv =====
// Package: shared types, constants and helper functions for the two-axis servo stepper.
package tass_pkg;

    localparam int ANGLE_W    = 8;
    localparam int SETTLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
    localparam logic [ANGLE_W-1:0] ALPHA_HOME = 8'd90;
    localparam logic [ANGLE_W-1:0] BETA_HOME  = 8'd0;

    localparam logic [SETTLE_W-1:0] SETTLE_RST   = 16'd50;
    localparam logic [ANGLE_W-1:0]  PEN_UP_RST   = 8'd90;
    localparam logic [ANGLE_W-1:0]  PEN_DOWN_RST = 8'd0;
    localparam logic [ANGLE_W-1:0]  TRIM_RST     = 8'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_UP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_DOWN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_TRIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_TRIM    = 3'd4;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_MOVE    = 2'd1,
        REQ_LIFT    = 2'd2,
        REQ_STANDBY = 2'd3
    } t_req_kind;

    typedef struct packed {
        t_req_kind          req_type;
        logic [ANGLE_W-1:0] goal_alpha;
        logic [ANGLE_W-1:0] goal_beta;
        logic               jump_now;
        logic               raise_pen;
    } t_req;

    typedef struct packed {
        logic [ANGLE_W-1:0] alpha_drive;
        logic [ANGLE_W-1:0] beta_drive;
        logic [ANGLE_W-1:0] pen_angle;
        logic [ANGLE_W-1:0] alpha_now;
        logic [ANGLE_W-1:0] beta_now;
        logic               busy_res;
        logic               pen_raised;
    } t_res;

    typedef struct packed {
        logic [ANGLE_W-1:0] pos;
        logic [ANGLE_W-1:0] goal;
        logic [ANGLE_W-1:0] origin;
    } t_axis;

    function automatic logic [ANGLE_W-1:0] clamp180(input logic [ANGLE_W:0] v);
        return (v > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : v[ANGLE_W-1:0];
    endfunction

    function automatic logic [ANGLE_W-1:0] drive_of(input logic [ANGLE_W-1:0] pos,
                                                   input logic [ANGLE_W-1:0] trim);
        logic [ANGLE_W:0] sum;
        sum = {1'b0, pos} + {1'b0, trim};
        return ANGLE_MAX - clamp180(sum);
    endfunction

endpackage

// ===== design/tass_req_if.sv =====
// Interface: request channel carrying one stepper request.
interface tass_req_if;
    import tass_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/tass_res_if.sv =====
// Interface: result channel carrying drive values and status.
interface tass_res_if;
    import tass_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/tass_step.sv =====
// Step selection: ranks remaining path fractions and steps the lagging axis, or both axes on a tie.
module tass_step (
    input  tass_pkg::t_axis              i_alpha,
    input  tass_pkg::t_axis              i_beta,
    output logic [tass_pkg::ANGLE_W-1:0] o_alpha_next,
    output logic [tass_pkg::ANGLE_W-1:0] o_beta_next
);
    import tass_pkg::*;

    logic [ANGLE_W-1:0]   da, db, ra, rb;
    logic [2*ANGLE_W-1:0] lhs, rhs;
    logic                 alpha_go, beta_go;

    function automatic logic [ANGLE_W-1:0] absdiff(input logic [ANGLE_W-1:0] a,
                                                  input logic [ANGLE_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [ANGLE_W-1:0] step_toward(input logic [ANGLE_W-1:0] pos,
                                                      input logic [ANGLE_W-1:0] goal);
        logic [ANGLE_W-1:0] res;
        if (pos < goal) begin
            res = clamp180({1'b0, pos} + 9'd1);
        end else if (pos > goal) begin
            res = pos - 8'd1;
        end else begin
            res = pos;
        end
        return res;
    endfunction

    always_comb begin
        da  = absdiff(i_alpha.goal, i_alpha.origin);
        db  = absdiff(i_beta.goal, i_beta.origin);
        ra  = absdiff(i_alpha.goal, i_alpha.pos);
        rb  = absdiff(i_beta.goal, i_beta.pos);
        lhs = {{ANGLE_W{1'b0}}, ra} * {{ANGLE_W{1'b0}}, db};
        rhs = {{ANGLE_W{1'b0}}, rb} * {{ANGLE_W{1'b0}}, da};
        // zero planned travel ranks lowest; both zero counts as a tie
        if (da == '0 && db == '0) begin
            alpha_go = 1'b1;
            beta_go  = 1'b1;
        end else if (da == '0) begin
            alpha_go = 1'b0;
            beta_go  = 1'b1;
        end else if (db == '0) begin
            alpha_go = 1'b1;
            beta_go  = 1'b0;
        end else begin
            alpha_go = (lhs >= rhs);
            beta_go  = (lhs <= rhs);
        end
        o_alpha_next = alpha_go ? step_toward(i_alpha.pos, i_alpha.goal) : i_alpha.pos;
        o_beta_next  = beta_go  ? step_toward(i_beta.pos, i_beta.goal)   : i_beta.pos;
    end

endmodule

// ===== design/two_axis_servo_stepper_core.sv =====
// Top level: two-axis servo stepper with pen lift, settle countdown and drive outputs.
// An accepted request passes the request register, then the result register, to the output.
// Throughput: one request per cycle while results are taken; each register holds one item.
// The state update is a single pass through the step ranking (two 8x8 products and a compare).
// Synchronous active-low reset: alpha 90, beta 0, pen at 90, nothing pending,
// configuration registers at their defaults, both pipeline registers empty.
module two_axis_servo_stepper_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tass_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tass_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tass_req_if.sink                         i_req,
    tass_res_if.source                       o_res
);
    import tass_pkg::*;

    logic [SETTLE_W-1:0] r_settle_ticks;
    logic [ANGLE_W-1:0]  r_pen_up, r_pen_down, r_alpha_trim, r_beta_trim;

    logic [ANGLE_W-1:0]  r_alpha_pos, r_beta_pos, r_alpha_origin, r_beta_origin;
    logic [ANGLE_W-1:0]  r_alpha_goal, r_beta_goal, r_vertical_pos;
    logic                r_pending, r_jump_pending;
    logic [SETTLE_W-1:0] r_settle_count;

    logic [ANGLE_W-1:0]  n_alpha_pos, n_beta_pos, n_alpha_origin, n_beta_origin;
    logic [ANGLE_W-1:0]  n_alpha_goal, n_beta_goal, n_vertical_pos;
    logic                n_pending, n_jump_pending;
    logic [SETTLE_W-1:0] n_settle_count;

    logic                r_in_valid;
    t_req                r_in_data;
    logic                r_out_valid;
    t_res                r_out_data;
    t_res                n_out_data;

    logic                advance, fire;
    logic [ANGLE_W-1:0]  up_ang, want_ang, step_alpha, step_beta;
    t_axis               alpha_axis, beta_axis;

    assign advance     = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    assign alpha_axis = '{pos: r_alpha_pos, goal: r_alpha_goal, origin: r_alpha_origin};
    assign beta_axis  = '{pos: r_beta_pos, goal: r_beta_goal, origin: r_beta_origin};

    tass_step u_step (
        .i_alpha      (alpha_axis),
        .i_beta       (beta_axis),
        .o_alpha_next (step_alpha),
        .o_beta_next  (step_beta)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_RST;
            r_pen_up       <= PEN_UP_RST;
            r_pen_down     <= PEN_DOWN_RST;
            r_alpha_trim   <= TRIM_RST;
            r_beta_trim    <= TRIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data;
                CFG_PEN_UP:       r_pen_up       <= i_cfg_data[ANGLE_W-1:0];
                CFG_PEN_DOWN:     r_pen_down     <= i_cfg_data[ANGLE_W-1:0];
                CFG_ALPHA_TRIM:   r_alpha_trim   <= i_cfg_data[ANGLE_W-1:0];
                CFG_BETA_TRIM:    r_beta_trim    <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_alpha_pos    = r_alpha_pos;
        n_beta_pos     = r_beta_pos;
        n_alpha_origin = r_alpha_origin;
        n_beta_origin  = r_beta_origin;
        n_alpha_goal   = r_alpha_goal;
        n_beta_goal    = r_beta_goal;
        n_vertical_pos = r_vertical_pos;
        n_pending      = r_pending;
        n_jump_pending = r_jump_pending;
        n_settle_count = r_settle_count;
        up_ang         = clamp180({1'b0, r_pen_up});
        want_ang       = r_in_data.raise_pen ? up_ang : clamp180({1'b0, r_pen_down});

        case (r_in_data.req_type)
            REQ_TICK: begin
                if (r_settle_count != '0) begin
                    n_settle_count = r_settle_count - 1'b1;
                end else if (r_pending) begin
                    if (r_jump_pending) begin
                        n_alpha_pos    = r_alpha_goal;
                        n_beta_pos     = r_beta_goal;
                        n_alpha_origin = r_alpha_goal;
                        n_beta_origin  = r_beta_goal;
                        n_jump_pending = 1'b0;
                        n_settle_count = r_settle_ticks;
                    end else if (r_alpha_pos == r_alpha_goal && r_beta_pos == r_beta_goal) begin
                        n_pending = 1'b0;
                    end else begin
                        n_alpha_pos = step_alpha;
                        n_beta_pos  = step_beta;
                    end
                end
            end
            REQ_MOVE: begin
                n_alpha_origin = r_alpha_pos;
                n_beta_origin  = r_beta_pos;
                n_alpha_goal   = clamp180({1'b0, r_in_data.goal_alpha});
                n_beta_goal    = clamp180({1'b0, r_in_data.goal_beta});
                n_jump_pending = r_jump_pending || r_in_data.jump_now;
                n_pending      = 1'b1;
            end
            REQ_LIFT: begin
                if (r_vertical_pos != want_ang) begin
                    n_vertical_pos = want_ang;
                    n_pending      = 1'b1;
                    n_settle_count = r_settle_ticks;
                end
            end
            REQ_STANDBY: begin
                n_alpha_goal = ALPHA_HOME;
                n_beta_goal  = BETA_HOME;
                n_alpha_pos  = ALPHA_HOME;
                n_beta_pos   = BETA_HOME;
            end
            default: ;
        endcase

        n_out_data.alpha_drive = drive_of(n_alpha_pos, r_alpha_trim);
        n_out_data.beta_drive  = drive_of(n_beta_pos, r_beta_trim);
        n_out_data.pen_angle   = n_vertical_pos;
        n_out_data.alpha_now   = n_alpha_pos;
        n_out_data.beta_now    = n_beta_pos;
        n_out_data.busy_res    = n_pending;
        n_out_data.pen_raised  = (n_vertical_pos == up_ang);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_pos    <= ALPHA_HOME;
            r_beta_pos     <= BETA_HOME;
            r_alpha_origin <= '0;
            r_beta_origin  <= '0;
            r_alpha_goal   <= ALPHA_HOME;
            r_beta_goal    <= BETA_HOME;
            r_vertical_pos <= PEN_UP_RST;
            r_pending      <= 1'b0;
            r_jump_pending <= 1'b0;
            r_settle_count <= '0;
        end else if (fire) begin
            r_alpha_pos    <= n_alpha_pos;
            r_beta_pos     <= n_beta_pos;
            r_alpha_origin <= n_alpha_origin;
            r_beta_origin  <= n_beta_origin;
            r_alpha_goal   <= n_alpha_goal;
            r_beta_goal    <= n_beta_goal;
            r_vertical_pos <= n_vertical_pos;
            r_pending      <= n_pending;
            r_jump_pending <= n_jump_pending;
            r_settle_count <= n_settle_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_data <= i_req.data;
        end
        if (fire) begin
            r_out_data <= n_out_data;
        end
    end

    // a jump is only ever armed together with a pending move
    a_jump_implies_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jump_pending |-> r_pending)
        else $error("jump armed without pending move");

    // positions and goals stay within servo range
    a_angles_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alpha_pos <= ANGLE_MAX && r_beta_pos <= ANGLE_MAX &&
        r_alpha_goal <= ANGLE_MAX && r_beta_goal <= ANGLE_MAX &&
        r_vertical_pos <= ANGLE_MAX)
        else $error("angle out of range");

    // a tick during the settle wait only counts down
    a_settle_holds_axes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_data.req_type == REQ_TICK && r_settle_count != '0 |=>
        $stable(r_alpha_pos) && $stable(r_beta_pos) &&
        r_settle_count == $past(r_settle_count) - 1'b1)
        else $error("axes moved during settle wait");

    // the request stage never drops an item while the result side stalls
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_data))
        else $error("request register lost an item");

endmodule

// ===== dv/tb_two_axis_servo_stepper_core.sv =====
// Testbench: checks the two-axis servo stepper against a cycle-free predictor under random traffic.
module tb_two_axis_servo_stepper_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tass_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {RCV_OPEN, RCV_LIGHT, RCV_HEAVY, RCV_THIRD} t_rcv_mode;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tass_req_if req_if();
    tass_res_if res_if();

    two_axis_servo_stepper_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    always #2 i_clk = ~i_clk;

    // predicted block state and configuration
    logic [SETTLE_W-1:0] c_settle = SETTLE_RST;
    logic [ANGLE_W-1:0]  c_up     = PEN_UP_RST;
    logic [ANGLE_W-1:0]  c_down   = PEN_DOWN_RST;
    logic [ANGLE_W-1:0]  c_atrim  = TRIM_RST;
    logic [ANGLE_W-1:0]  c_btrim  = TRIM_RST;

    logic [ANGLE_W-1:0]  alpha_deg   = ALPHA_HOME;
    logic [ANGLE_W-1:0]  beta_deg    = BETA_HOME;
    logic [ANGLE_W-1:0]  alpha_start = '0;
    logic [ANGLE_W-1:0]  beta_start  = '0;
    logic [ANGLE_W-1:0]  alpha_tgt   = ALPHA_HOME;
    logic [ANGLE_W-1:0]  beta_tgt    = BETA_HOME;
    logic [ANGLE_W-1:0]  pen_deg     = PEN_UP_RST;
    logic                motion_busy = 1'b0;
    logic                jump_armed  = 1'b0;
    logic [SETTLE_W-1:0] settle_left = '0;

    t_res servo_expected_q[$];

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int cfg_settings = 0;
    int cycles       = 0;
    int burst_left   = 1;
    bit pace_on      = 1'b1;

    int        hold_ask   = 0;
    int        hold_seen  = 0;
    int        hold_left  = 0;
    int        stall_tick = 0;
    t_rcv_mode stall_mode = RCV_OPEN;

    function automatic logic [ANGLE_W-1:0] sat180(logic [ANGLE_W:0] v);
        return (v > 9'd180) ? 8'd180 : v[ANGLE_W-1:0];
    endfunction

    function automatic logic [ANGLE_W-1:0] gap_of(logic [ANGLE_W-1:0] a, logic [ANGLE_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [ANGLE_W-1:0] nudge(logic [ANGLE_W-1:0] p, logic [ANGLE_W-1:0] g);
        if (p < g) return sat180({1'b0, p} + 9'd1);
        if (p > g) return p - 8'd1;
        return p;
    endfunction

    function automatic void step_axes();
        logic [ANGLE_W-1:0] da, db, ra, rb;
        logic [15:0]        lhs, rhs;
        int                 rank;
        da = gap_of(alpha_tgt, alpha_start);
        db = gap_of(beta_tgt, beta_start);
        ra = gap_of(alpha_tgt, alpha_deg);
        rb = gap_of(beta_tgt, beta_deg);
        if (da == 0 && db == 0) begin
            rank = 0;
        end else if (da == 0) begin
            rank = -1;
        end else if (db == 0) begin
            rank = 1;
        end else begin
            lhs  = 16'(ra) * 16'(db);
            rhs  = 16'(rb) * 16'(da);
            rank = (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
        end
        if (rank >= 0) alpha_deg = nudge(alpha_deg, alpha_tgt);
        if (rank <= 0) beta_deg = nudge(beta_deg, beta_tgt);
    endfunction

    function automatic t_res next_servo_result(t_req r);
        t_res               o;
        logic [ANGLE_W-1:0] up, want;
        up = sat180({1'b0, c_up});
        case (r.req_type)
            REQ_TICK: begin
                if (settle_left != 0) begin
                    settle_left = settle_left - 1'b1;
                end else if (motion_busy) begin
                    if (jump_armed) begin
                        alpha_deg   = alpha_tgt;
                        beta_deg    = beta_tgt;
                        alpha_start = alpha_tgt;
                        beta_start  = beta_tgt;
                        jump_armed  = 1'b0;
                        settle_left = c_settle;
                    end else if (alpha_deg == alpha_tgt && beta_deg == beta_tgt) begin
                        motion_busy = 1'b0;
                    end else begin
                        step_axes();
                    end
                end
            end
            REQ_MOVE: begin
                alpha_start = alpha_deg;
                beta_start  = beta_deg;
                alpha_tgt   = sat180({1'b0, r.goal_alpha});
                beta_tgt    = sat180({1'b0, r.goal_beta});
                jump_armed  = jump_armed | r.jump_now;
                motion_busy = 1'b1;
            end
            REQ_LIFT: begin
                want = r.raise_pen ? up : sat180({1'b0, c_down});
                if (pen_deg != want) begin
                    pen_deg     = want;
                    motion_busy = 1'b1;
                    settle_left = c_settle;
                end
            end
            default: begin
                alpha_tgt = ALPHA_HOME;
                beta_tgt  = BETA_HOME;
                alpha_deg = ALPHA_HOME;
                beta_deg  = BETA_HOME;
            end
        endcase
        o.alpha_drive = 8'd180 - sat180({1'b0, alpha_deg} + {1'b0, c_atrim});
        o.beta_drive  = 8'd180 - sat180({1'b0, beta_deg} + {1'b0, c_btrim});
        o.pen_angle   = pen_deg;
        o.alpha_now   = alpha_deg;
        o.beta_now    = beta_deg;
        o.busy_res    = motion_busy;
        o.pen_raised  = (pen_deg == up);
        return o;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, servo_expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: long hold-off on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen    <= hold_ask;
            hold_left    <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            if (stall_tick == 0) stall_mode <= t_rcv_mode'($urandom_range(0, 3));
            stall_tick <= (stall_tick == 96) ? 0 : stall_tick + 1;
            case (stall_mode)
                RCV_OPEN:  res_if.ready <= 1'b1;
                RCV_LIGHT: res_if.ready <= ($urandom_range(0, 3) != 0);
                RCV_HEAVY: res_if.ready <= ($urandom_range(0, 9) < 3);
                default:   res_if.ready <= (stall_tick % 3 == 0);
            endcase
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (servo_expected_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                want = servo_expected_q.pop_front();
                check_field("alpha_drive", want.alpha_drive, res_if.data.alpha_drive);
                check_field("beta_drive", want.beta_drive, res_if.data.beta_drive);
                check_field("pen_angle", want.pen_angle, res_if.data.pen_angle);
                check_field("alpha_now", want.alpha_now, res_if.data.alpha_now);
                check_field("beta_now", want.beta_now, res_if.data.beta_now);
                check_field("busy_res", want.busy_res, res_if.data.busy_res);
                check_field("pen_raised", want.pen_raised, res_if.data.pen_raised);
                results_seen++;
            end
        end
    end

    task automatic send_req(t_req r);
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        servo_expected_q.push_back(next_servo_result(r));
        items_sent++;
        if (pace_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (servo_expected_q.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SETTLE_TICKS: c_settle = val;
            CFG_PEN_UP:       c_up     = val[ANGLE_W-1:0];
            CFG_PEN_DOWN:     c_down   = val[ANGLE_W-1:0];
            CFG_ALPHA_TRIM:   c_atrim  = val[ANGLE_W-1:0];
            CFG_BETA_TRIM:    c_btrim  = val[ANGLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(logic [15:0] settle, logic [7:0] up, logic [7:0] down,
                           logic [7:0] atrim, logic [7:0] btrim);
        drain();
        write_reg(CFG_SETTLE_TICKS, settle);
        write_reg(CFG_PEN_UP, 16'(up));
        write_reg(CFG_PEN_DOWN, 16'(down));
        write_reg(CFG_ALPHA_TRIM, 16'(atrim));
        write_reg(CFG_BETA_TRIM, 16'(btrim));
        cfg_we <= 1'b0;
        cfg_settings++;
    endtask

    function automatic t_req mk_req(t_req_kind k, int ga, int gb, bit j, bit rp);
        t_req r;
        r.req_type   = k;
        r.goal_alpha = 8'(ga);
        r.goal_beta  = 8'(gb);
        r.jump_now   = j;
        r.raise_pen  = rp;
        return r;
    endfunction

    function automatic t_req any_req();
        return mk_req(t_req_kind'($urandom_range(0, 3)), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    function automatic t_req tick_req();
        t_req r;
        r = any_req();
        r.req_type = REQ_TICK;
        return r;
    endfunction

    function automatic logic [7:0] near_angle(logic [7:0] p);
        int v;
        v = int'(p) + $urandom_range(0, 24) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic tick_until_idle();
        int guard;
        guard = 0;
        while ((motion_busy || settle_left != 0) && guard < 80) begin
            if ($urandom_range(0, 29) == 0) send_req(any_req());
            else send_req(tick_req());
            guard++;
        end
    endtask

    task automatic walk_seq();
        t_req r;
        r = any_req();
        r.req_type = REQ_MOVE;
        if ($urandom_range(0, 5) != 0) begin
            r.goal_alpha = near_angle(alpha_deg);
            r.goal_beta  = near_angle(beta_deg);
        end
        r.jump_now = ($urandom_range(0, 3) == 0);
        send_req(r);
        tick_until_idle();
    endtask

    task automatic lift_seq();
        t_req r;
        r = any_req();
        r.req_type = REQ_LIFT;
        if ($urandom_range(0, 4) != 0) r.raise_pen = (pen_deg != sat180({1'b0, c_up}));
        send_req(r);
        tick_until_idle();
    endtask

    task automatic run_mix(int n, int walk_w, int lift_w);
        int target, pick;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < walk_w) walk_seq();
            else if (pick < walk_w + lift_w) lift_seq();
            else send_req(any_req());
        end
    endtask

    task automatic test_directed();
        send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
        send_req(mk_req(REQ_MOVE, 255, 255, 0, 0));
        repeat (3) send_req(mk_req(REQ_TICK, 255, 255, 1, 1));
        send_req(mk_req(REQ_STANDBY, 0, 0, 0, 0));
        send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
        // alpha has no travel, so beta walks alone
        send_req(mk_req(REQ_MOVE, 90, 3, 0, 0));
        repeat (4) send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
        // a second move keeps the waiting jump armed
        send_req(mk_req(REQ_MOVE, 0, 180, 1, 0));
        send_req(mk_req(REQ_MOVE, 10, 10, 0, 0));
        send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
        send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
        send_req(mk_req(REQ_LIFT, 0, 0, 0, 1));
        send_req(mk_req(REQ_LIFT, 0, 0, 0, 0));
        send_req(mk_req(REQ_LIFT, 0, 0, 0, 0));
        send_req(mk_req(REQ_MOVE, 170, 90, 0, 1));
        send_req(mk_req(REQ_STANDBY, 255, 255, 1, 1));
        send_req(mk_req(REQ_TICK, 0, 0, 0, 0));
    endtask

    task automatic test_walks();
        set_cfg(16'($urandom_range(0, 3)), 8'd120, 8'd30, 8'($urandom_range(0, 20)),
                8'($urandom_range(0, 20)));
        run_mix(400, 75, 10);
    endtask

    task automatic test_lift_settle();
        set_cfg(16'd3, 8'd180, 8'd0, 8'd0, 8'd0);
        pace_on = 1'b0;
        run_mix(120, 30, 50);
        pace_on = 1'b1;
        run_mix(130, 30, 50);
    endtask

    task automatic test_backpressure();
        set_cfg(16'd1, 8'd150, 8'd20, 8'd30, 8'd5);
        pace_on = 1'b0;
        hold_ask <= hold_ask + 1;
        run_mix(60, 60, 20);
        drain();
        pace_on = 1'b1;
        run_mix(40, 50, 30);
    endtask

    task automatic test_cfg_extremes();
        set_cfg(16'd0, 8'd255, 8'd200, 8'd255, 8'd255);
        run_mix(150, 45, 30);
        set_cfg(16'd2, 8'd0, 8'd180, 8'd180, 8'd0);
        run_mix(150, 45, 30);
        repeat (2) begin
            set_cfg(16'($urandom_range(0, 4)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
            run_mix(150, 50, 25);
        end
        // longest settle last: its countdown never runs out
        set_cfg(16'hFFFF, 8'd90, 8'd0, 8'd0, 8'd180);
        run_mix(60, 40, 40);
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_walks();
        test_lift_settle();
        test_backpressure();
        test_cfg_extremes();
        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests and %0d checked results over %0d register settings,",
                 items_sent, results_seen, cfg_settings);
        $display("with stepped and instant moves, lifts, standby and result back-pressure.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tass_pkg.sv
design/tass_req_if.sv
design/tass_res_if.sv
design/tass_step.sv
design/two_axis_servo_stepper_core.sv
dv/tb_two_axis_servo_stepper_core.sv
